[design/wnhs_pkg.sv]
// Shared types and constants of the weighted next-hop selector.
package wnhs_pkg;

  // Default sizes of the group table
  localparam int unsigned DEF_GROUPS      = 8;
  localparam int unsigned DEF_SLOTS       = 16;
  localparam int unsigned DEF_WEIGHT_BITS = 16;
  localparam int unsigned DEF_HOP_BITS    = 32;

  // Random fraction is a value over 2**FRAC_BITS
  localparam int unsigned FRAC_BITS = 16;

  // Register port
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned REG_IDX_W = APB_AW - 2;

  localparam logic [REG_IDX_W-1:0] REG_EXPIRE_TICKS  = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_GROUPS_IN_USE = 1'd1;

  // Request function codes
  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_SELECT = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  group_index;
    logic [3:0]  slot_index;
    logic        slot_used;
    logic [15:0] entry_weight;
    logic [31:0] entry_hop;
    logic [15:0] random_fraction;
  } req_t;

  typedef struct packed {
    logic [31:0] hop_id;
    logic [2:0]  result_group;
    logic        last_result;
    logic        expired;
  } hop_rsp_t;

  typedef struct packed {
    logic                 we;
    logic [REG_IDX_W-1:0] idx;
    logic [APB_DW-1:0]    data;
  } cfg_wr_t;

  typedef struct packed {
    logic restart;
    logic tick;
  } timer_ctrl_t;

endpackage

[design/wnhs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module wnhs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/wnhs_timer.sv]
// Configuration registers and idle expiry countdown.
module wnhs_timer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wnhs_pkg::cfg_wr_t     cfg_i,
  input  wnhs_pkg::timer_ctrl_t ctrl_i,
  output logic [31:0]           expire_ticks_o,
  output logic [3:0]            groups_in_use_o,
  output logic                  expire_o
);
  import wnhs_pkg::*;

  logic [31:0] expire_q, expire_d;
  logic [3:0]  giu_q, giu_d;
  logic [31:0] count_q, count_d;
  logic        reported_q, reported_d;

  always_comb begin
    expire_d   = expire_q;
    giu_d      = giu_q;
    count_d    = count_q;
    reported_d = reported_q;
    expire_o   = 1'b0;

    if (cfg_i.we) begin
      unique case (cfg_i.idx)
        REG_EXPIRE_TICKS: begin
          expire_d   = cfg_i.data;
          count_d    = cfg_i.data;
          reported_d = 1'b0;
        end
        REG_GROUPS_IN_USE: begin
          giu_d = cfg_i.data[3:0];
        end
        default: begin
        end
      endcase
    end

    // Reload on a select, only while expiry is enabled
    if (ctrl_i.restart && expire_q != '0) begin
      count_d    = expire_q;
      reported_d = 1'b0;
    end

    if (ctrl_i.tick && expire_q != '0) begin
      if (count_q > 32'd1) begin
        count_d = count_q - 32'd1;
      end else begin
        count_d = '0;
        if (!reported_q) begin
          reported_d = 1'b1;
          expire_o   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expire_q   <= '0;
      giu_q      <= 4'd1;
      count_q    <= '0;
      reported_q <= 1'b0;
    end else begin
      expire_q   <= expire_d;
      giu_q      <= giu_d;
      count_q    <= count_d;
      reported_q <= reported_d;
    end
  end

  assign expire_ticks_o  = expire_q;
  assign groups_in_use_o = giu_q;

endmodule

[design/weighted_next_hop_selector_core.sv]
// Top level of the weighted next-hop selector: sequencer, slot walker and table.
//
// Requests enter on req_i when start is high and busy is low. A write request
// loads or clears one slot of one replication group: it reads the old
// weight, then updates the slot and the group total. A tick request and an
// out-of-range or unknown request are handled in the idle state; an expiring
// tick puts one result with expired set on the result port in the following
// cycle. A select request walks groups 0 .. groups_in_use-1, capped at GROUPS,
// and skips empty groups. For a nonempty group it does the threshold multiply,
// then takes slots in ascending weight order, rescanning the weight RAM for
// each, until the running sum reaches the threshold or the last valid slot is
// taken, then reads the hop; the result appears on result_o with
// result_strobe_o for exactly one cycle. A final visit to the group state
// closes the request. The single compare unit rescans the weight RAM once for
// every slot it takes. The receiver cannot stall: each result is valid for
// one cycle only. The last result of a select carries last_result.
// Registers sit on an APB port: expire_ticks at 0x0, groups_in_use at 0x4.
// Reset clears slot valid bits, group totals, counts and the expiry timer;
// slot weights and hops stay undefined until written. No clearing pass.
module weighted_next_hop_selector_core #(
  parameter int unsigned GROUPS      = wnhs_pkg::DEF_GROUPS,
  parameter int unsigned SLOTS       = wnhs_pkg::DEF_SLOTS,
  parameter int unsigned WEIGHT_BITS = wnhs_pkg::DEF_WEIGHT_BITS,
  parameter int unsigned HOP_BITS    = wnhs_pkg::DEF_HOP_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  wnhs_pkg::req_t                req_i,
  output logic                          result_strobe_o,
  output wnhs_pkg::hop_rsp_t            result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wnhs_pkg::APB_AW-1:0]   paddr,
  input  logic [wnhs_pkg::APB_DW-1:0]   pwdata,
  output logic [wnhs_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import wnhs_pkg::*;

  localparam int unsigned GW  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int unsigned SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned AW  = (GROUPS * SLOTS > 1) ? $clog2(GROUPS * SLOTS) : 1;
  localparam int unsigned CW  = $clog2(SLOTS + 1);
  localparam int unsigned GCW = $clog2(GROUPS + 1);
  localparam int unsigned TW  = WEIGHT_BITS + $clog2(SLOTS);
  localparam int unsigned PW  = TW + FRAC_BITS;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_WR_UPD = 6'b000010,
    ST_GRP    = 6'b000100,
    ST_SCAN   = 6'b001000,
    ST_PICK   = 6'b010000,
    ST_HOP    = 6'b100000
  } state_e;

  function automatic logic [AW-1:0] slot_addr(logic [GW-1:0] g, logic [SW-1:0] s);
    return AW'(g) * AW'(SLOTS) + AW'(s);
  endfunction

  // ------------------------------------------------------------------
  // Register port and expiry timer
  // ------------------------------------------------------------------
  cfg_wr_t     cfg_wr;
  timer_ctrl_t tmr_ctrl;
  logic [31:0] expire_ticks;
  logic [3:0]  groups_in_use;
  logic        expire_fire;

  assign cfg_wr.we   = psel && penable && pwrite;
  assign cfg_wr.idx  = paddr[APB_AW-1:2];
  assign cfg_wr.data = pwdata;
  assign pready      = 1'b1;

  always_comb begin
    unique case (paddr[APB_AW-1:2])
      REG_EXPIRE_TICKS:  prdata = expire_ticks;
      REG_GROUPS_IN_USE: prdata = APB_DW'(groups_in_use);
      default:           prdata = '0;
    endcase
  end

  wnhs_timer u_timer (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_wr),
    .ctrl_i          (tmr_ctrl),
    .expire_ticks_o  (expire_ticks),
    .groups_in_use_o (groups_in_use),
    .expire_o        (expire_fire)
  );

  // ------------------------------------------------------------------
  // Sequencer state
  // ------------------------------------------------------------------
  state_e            state_q, state_d;
  req_t              req_q, req_d;
  logic [GCW-1:0]    grp_q, grp_d;
  logic [GCW-1:0]    limit_q, limit_d;
  logic [TW-1:0]     thr_q, thr_d;
  logic [TW-1:0]     cum_q, cum_d;
  logic [CW-1:0]     scan_q, scan_d;
  logic              rd_vld_q, rd_vld_d;
  logic [SW-1:0]     rd_slot_q, rd_slot_d;
  logic [WEIGHT_BITS-1:0] best_w_q, best_w_d;
  logic [SW-1:0]     best_s_q, best_s_d;
  logic              found_q, found_d;
  logic [WEIGHT_BITS-1:0] prev_w_q, prev_w_d;
  logic [SW-1:0]     prev_s_q, prev_s_d;
  logic              first_q, first_d;
  logic [CW-1:0]     step_q, step_d;
  logic [SLOTS-1:0]  valid_q [GROUPS];
  logic [SLOTS-1:0]  valid_d [GROUPS];
  logic [CW-1:0]     cnt_q [GROUPS];
  logic [CW-1:0]     cnt_d [GROUPS];
  logic [TW-1:0]     total_q [GROUPS];
  logic [TW-1:0]     total_d [GROUPS];
  logic              strobe_q, strobe_d;
  hop_rsp_t          res_q, res_d;

  // Table memories
  logic                   w_we, h_we;
  logic [AW-1:0]          w_raddr, h_raddr, wr_addr;
  logic [WEIGHT_BITS-1:0] w_rdata;
  logic [HOP_BITS-1:0]    h_rdata;

  logic                   accept;
  logic [GW-1:0]          gsel;
  logic [GW-1:0]          wr_g;
  logic [SW-1:0]          wr_s;
  logic [PW-1:0]          prod;
  logic [TW-1:0]          cum_sum;
  logic                   after_prev, before_best, take;
  logic                   later_any;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign gsel   = grp_q[GW-1:0];
  assign wr_g   = GW'(req_q.group_index);
  assign wr_s   = SW'(req_q.slot_index);
  assign wr_addr = slot_addr(wr_g, wr_s);

  // Timer strobes: a select reloads the countdown, a tick advances it
  assign tmr_ctrl.restart = accept && (req_i.func == FUNC_SELECT);
  assign tmr_ctrl.tick    = accept && (req_i.func == FUNC_TICK);

  wnhs_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (GROUPS * SLOTS)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (wr_addr),
    .wdata_i (WEIGHT_BITS'(req_q.entry_weight)),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  wnhs_ram #(
    .WIDTH (HOP_BITS),
    .DEPTH (GROUPS * SLOTS)
  ) u_hop_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (wr_addr),
    .wdata_i (HOP_BITS'(req_q.entry_hop)),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  // Threshold multiply: fraction times group total, keep the integer part
  assign prod = PW'(req_q.random_fraction) * PW'(total_q[gsel]);

  // Shared compare unit: is the slot on the read port the next one in weight order?
  assign after_prev  = first_q || (w_rdata > prev_w_q) ||
                       ((w_rdata == prev_w_q) && (rd_slot_q > prev_s_q));
  assign before_best = !found_q || (w_rdata < best_w_q) ||
                       ((w_rdata == best_w_q) && (rd_slot_q < best_s_q));
  assign take        = rd_vld_q && valid_q[gsel][rd_slot_q] && after_prev && before_best;

  assign cum_sum = cum_q + TW'(best_w_q);

  // Any nonempty group still ahead of the current one
  always_comb begin
    later_any = 1'b0;
    for (int j = 0; j < int'(GROUPS); j++) begin
      if (j > int'(grp_q) && j < int'(limit_q) && cnt_q[j] != '0) begin
        later_any = 1'b1;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    grp_d     = grp_q;
    limit_d   = limit_q;
    thr_d     = thr_q;
    cum_d     = cum_q;
    scan_d    = scan_q;
    rd_vld_d  = 1'b0;
    rd_slot_d = rd_slot_q;
    best_w_d  = best_w_q;
    best_s_d  = best_s_q;
    found_d   = found_q;
    prev_w_d  = prev_w_q;
    prev_s_d  = prev_s_q;
    first_d   = first_q;
    step_d    = step_q;
    valid_d   = valid_q;
    cnt_d     = cnt_q;
    total_d   = total_q;
    strobe_d  = 1'b0;
    res_d     = res_q;
    w_we      = 1'b0;
    h_we      = 1'b0;
    w_raddr   = slot_addr(gsel, scan_q[SW-1:0]);
    h_raddr   = slot_addr(gsel, best_s_q);

    unique case (state_q)
      ST_IDLE: begin
        // Read the old weight early so a write can retire it next cycle
        w_raddr = slot_addr(GW'(req_i.group_index), SW'(req_i.slot_index));
        if (accept) begin
          req_d = req_i;
          case (req_i.func)
            FUNC_WRITE: begin
              if (32'(req_i.group_index) < GROUPS && 32'(req_i.slot_index) < SLOTS) begin
                state_d = ST_WR_UPD;
              end
            end
            FUNC_SELECT: begin
              grp_d = '0;
              if (32'(groups_in_use) > GROUPS) begin
                limit_d = GCW'(GROUPS);
              end else begin
                limit_d = GCW'(groups_in_use);
              end
              state_d = ST_GRP;
            end
            FUNC_TICK: begin
              if (expire_fire) begin
                strobe_d = 1'b1;
                res_d    = '{hop_id: '0, result_group: '0, last_result: 1'b0,
                             expired: 1'b1};
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_WR_UPD: begin
        // Retire the old weight, add the new one, update slot bookkeeping
        total_d[wr_g] = total_q[wr_g]
                      - (valid_q[wr_g][wr_s] ? TW'(w_rdata) : '0)
                      + (req_q.slot_used ? TW'(WEIGHT_BITS'(req_q.entry_weight)) : '0);
        cnt_d[wr_g]   = cnt_q[wr_g] - CW'(valid_q[wr_g][wr_s]) + CW'(req_q.slot_used);
        valid_d[wr_g][wr_s] = req_q.slot_used;
        w_we    = req_q.slot_used;
        h_we    = req_q.slot_used;
        state_d = ST_IDLE;
      end

      ST_GRP: begin
        if (32'(grp_q) >= 32'(limit_q)) begin
          state_d = ST_IDLE;
        end else if (cnt_q[gsel] == '0) begin
          grp_d = grp_q + GCW'(1);
        end else begin
          thr_d   = prod[PW-1:FRAC_BITS];
          cum_d   = '0;
          first_d = 1'b1;
          found_d = 1'b0;
          step_d  = '0;
          scan_d  = '0;
          state_d = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Issue one weight read a cycle; compare the one that comes back
        if (32'(scan_q) < SLOTS) begin
          rd_vld_d  = 1'b1;
          rd_slot_d = scan_q[SW-1:0];
          scan_d    = scan_q + CW'(1);
        end
        if (take) begin
          best_w_d = w_rdata;
          best_s_d = rd_slot_q;
          found_d  = 1'b1;
        end
        if (rd_vld_q && rd_slot_q == SW'(SLOTS - 1)) begin
          state_d = ST_PICK;
        end
      end

      ST_PICK: begin
        cum_d    = cum_sum;
        prev_w_d = best_w_q;
        prev_s_d = best_s_q;
        first_d  = 1'b0;
        step_d   = step_q + CW'(1);
        if (cum_sum >= thr_q || CW'(step_q + CW'(1)) == cnt_q[gsel]) begin
          // Hop read of the chosen slot is issued on this edge
          state_d = ST_HOP;
        end else begin
          found_d = 1'b0;
          scan_d  = '0;
          state_d = ST_SCAN;
        end
      end

      ST_HOP: begin
        strobe_d = 1'b1;
        res_d    = '{hop_id: 32'(h_rdata), result_group: 3'(grp_q),
                     last_result: !later_any, expired: 1'b0};
        grp_d    = grp_q + GCW'(1);
        state_d  = ST_GRP;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      grp_q    <= '0;
      limit_q  <= '0;
      scan_q   <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
      first_q  <= 1'b1;
      step_q   <= '0;
      strobe_q <= 1'b0;
      for (int g = 0; g < int'(GROUPS); g++) begin
        valid_q[g] <= '0;
        cnt_q[g]   <= '0;
        total_q[g] <= '0;
      end
    end else begin
      state_q  <= state_d;
      grp_q    <= grp_d;
      limit_q  <= limit_d;
      scan_q   <= scan_d;
      rd_vld_q <= rd_vld_d;
      found_q  <= found_d;
      first_q  <= first_d;
      step_q   <= step_d;
      strobe_q <= strobe_d;
      valid_q  <= valid_d;
      cnt_q    <= cnt_d;
      total_q  <= total_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    thr_q     <= thr_d;
    cum_q     <= cum_d;
    rd_slot_q <= rd_slot_d;
    best_w_q  <= best_w_d;
    best_s_q  <= best_s_d;
    prev_w_q  <= prev_w_d;
    prev_s_q  <= prev_s_d;
    res_q     <= res_d;
  end

  assign result_strobe_o = strobe_q;
  assign result_o        = res_q;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------

  // Every finished scan must have found a next slot in weight order
  a_pick_found : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PICK) |-> found_q)
    else $error("slot walk ended without a candidate");

  // The running weight sum never passes the group total
  a_cum_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HOP) |-> (cum_q <= total_q[gsel]))
    else $error("running weight sum exceeds group total");

  // An expiry result only follows an accepted tick
  a_expiry_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && result_o.expired) |->
      $past(start && !busy && req_i.func == FUNC_TICK))
    else $error("expiry result without a tick request");

endmodule

[tb/weighted_next_hop_selector_core_tb.sv]
// Self-checking testbench for the weighted next-hop selector core.
module weighted_next_hop_selector_core_tb;
  import wnhs_pkg::*;

  localparam int unsigned HALF_PERIOD = 2;
  localparam int unsigned RESET_CYCLES = 10;
  // Watchdog bound, well above the slowest correct run: full selects over every
  // group and slot plus long gaps.
  localparam int unsigned CYCLE_LIMIT = 5000000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned PHASES = 6;
  localparam int unsigned PHASE_REQUESTS = 68;
  localparam int unsigned N_GROUPS = DEF_GROUPS;
  localparam int unsigned N_SLOTS = DEF_SLOTS;

  // Function code that the block ignores
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic result_strobe_o;
  hop_rsp_t result_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  // Shadow of the group table and the expiry timer
  bit [15:0] tbl_weight [N_GROUPS][N_SLOTS];
  bit [31:0] tbl_hop [N_GROUPS][N_SLOTS];
  bit [N_SLOTS-1:0] tbl_used [N_GROUPS];
  bit [19:0] tbl_sum [N_GROUPS];
  bit [31:0] idle_left;
  bit expiry_sent;
  bit [31:0] cfg_expire;
  bit [3:0] cfg_groups;

  // Hops and expiry events still owed by the block, oldest first
  hop_rsp_t awaited_results[$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit no_idle = 1'b0;

  weighted_next_hop_selector_core uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .req_i(req_i),
    .result_strobe_o(result_strobe_o),
    .result_o(result_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Watchdog: end a run that hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Walk the valid slots of group g in ascending weight order (ties by slot
  // index) and return the first hop whose running weight reaches the
  // threshold, else the heaviest one.
  function automatic bit [31:0] choose_hop(int unsigned g, bit [15:0] frac);
    int unsigned order [N_SLOTS];
    int unsigned n;
    int unsigned k;
    bit [63:0] threshold;
    bit [63:0] running;
    n = 0;
    running = '0;
    threshold = (64'(frac) * 64'(tbl_sum[g])) >> FRAC_BITS;
    for (int unsigned s = 0; s < N_SLOTS; s++) begin
      if (tbl_used[g][s]) begin
        k = n;
        while (k > 0 && tbl_weight[g][order[k-1]] > tbl_weight[g][s]) begin
          order[k] = order[k-1];
          k--;
        end
        order[k] = s;
        n++;
      end
    end
    for (k = 0; k < n; k++) begin
      running += 64'(tbl_weight[g][order[k]]);
      if (running >= threshold) return tbl_hop[g][order[k]];
    end
    return tbl_hop[g][order[n-1]];
  endfunction

  // Apply one accepted request to the shadow and queue the results it owes.
  function automatic void predict_outcome(req_t r);
    hop_rsp_t picks [N_GROUPS];
    hop_rsp_t ev;
    int unsigned cnt;
    int unsigned span;
    cnt = 0;
    case (r.func)
      FUNC_WRITE: begin
        // Drop the old weight from the total before loading or clearing
        if (tbl_used[r.group_index][r.slot_index])
          tbl_sum[r.group_index] -= 20'(tbl_weight[r.group_index][r.slot_index]);
        if (r.slot_used) begin
          tbl_weight[r.group_index][r.slot_index] = r.entry_weight;
          tbl_hop[r.group_index][r.slot_index] = r.entry_hop;
          tbl_used[r.group_index][r.slot_index] = 1'b1;
          tbl_sum[r.group_index] += 20'(r.entry_weight);
        end else begin
          tbl_used[r.group_index][r.slot_index] = 1'b0;
        end
      end
      FUNC_SELECT: begin
        if (cfg_expire != 0) begin
          idle_left = cfg_expire;
          expiry_sent = 1'b0;
        end
        span = (cfg_groups < N_GROUPS) ? cfg_groups : N_GROUPS;
        for (int unsigned g = 0; g < span; g++) begin
          if (tbl_used[g] != '0) begin
            picks[cnt] = '0;
            picks[cnt].hop_id = choose_hop(g, r.random_fraction);
            picks[cnt].result_group = 3'(g);
            cnt++;
          end
        end
        if (cnt > 0) picks[cnt-1].last_result = 1'b1;
        for (int unsigned i = 0; i < cnt; i++) awaited_results.push_back(picks[i]);
      end
      FUNC_TICK: begin
        if (cfg_expire != 0) begin
          if (idle_left > 1) begin
            idle_left--;
          end else begin
            idle_left = '0;
            if (!expiry_sent) begin
              expiry_sent = 1'b1;
              ev = '0;
              ev.expired = 1'b1;
              awaited_results.push_back(ev);
            end
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Compare every strobed result with the oldest one owed
  always @(posedge clk_i) begin
    hop_rsp_t want;
    if (rst_ni && result_strobe_o) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: hop_id %0h group %0d", result_o.hop_id,
               result_o.result_group);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        if (result_o.hop_id !== want.hop_id) begin
          $error("hop_id: expected %0h, got %0h", want.hop_id, result_o.hop_id);
          error_count++;
        end
        if (result_o.result_group !== want.result_group) begin
          $error("result_group: expected %0d, got %0d", want.result_group,
                 result_o.result_group);
          error_count++;
        end
        if (result_o.last_result !== want.last_result) begin
          $error("last_result: expected %0b, got %0b", want.last_result,
                 result_o.last_result);
          error_count++;
        end
        if (result_o.expired !== want.expired) begin
          $error("expired: expected %0b, got %0b", want.expired, result_o.expired);
          error_count++;
        end
      end
    end
  end

  // Mostly short gaps, a few long ones; none at all in burst phases
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Present one request, hold it until accepted, then idle for a random gap.
  // Keep start high across back-to-back requests.
  task automatic issue_request(input req_t r);
    int unsigned gap;
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_outcome(r);
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Random filler so that unused fields toggle too
  function automatic req_t noisy_request(logic [1:0] func);
    bit [95:0] noise;
    req_t r;
    noise = {$urandom, $urandom, $urandom};
    r = noise[$bits(req_t)-1:0];
    r.func = func;
    return r;
  endfunction

  task automatic send_write(input logic [2:0] g, input logic [3:0] s, input logic used,
                            input logic [15:0] w, input logic [31:0] hop);
    req_t r;
    r = noisy_request(FUNC_WRITE);
    r.group_index = g;
    r.slot_index = s;
    r.slot_used = used;
    r.entry_weight = w;
    r.entry_hop = hop;
    issue_request(r);
  endtask

  task automatic send_select(input logic [15:0] frac);
    req_t r;
    r = noisy_request(FUNC_SELECT);
    r.random_fraction = frac;
    issue_request(r);
  endtask

  // Drop start, wait for every owed result, then let writes and ticks that
  // owe nothing finish before touching the registers.
  task automatic wait_idle();
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // One APB transfer: setup cycle, access cycle, then an idle cycle
  task automatic apb_transfer(input logic wr, input logic [REG_IDX_W-1:0] idx,
                              input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_register(input logic [REG_IDX_W-1:0] idx,
                                input logic [APB_DW-1:0] want);
    logic [APB_DW-1:0] got;
    logic [APB_DW-1:0] mask;
    apb_transfer(1'b0, idx, '0, got);
    mask = (idx == REG_GROUPS_IN_USE) ? APB_DW'(4'hF) : '1;
    if ((got & mask) !== (want & mask)) begin
      $error("register %0d: expected %0h, got %0h", idx, want & mask, got & mask);
      error_count++;
    end
  endtask

  // Write a register while the block is idle, mirror it, read it back
  task automatic set_register(input logic [REG_IDX_W-1:0] idx,
                              input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] unused_rd;
    wait_idle();
    apb_transfer(1'b1, idx, value, unused_rd);
    if (idx == REG_EXPIRE_TICKS) begin
      cfg_expire = value;
      idle_left = value;
      expiry_sent = 1'b0;
    end else if (idx == REG_GROUPS_IN_USE) begin
      cfg_groups = value[3:0];
    end
    check_register(idx, value);
  endtask

  // Reset values, an empty table, disabled expiry and an unknown function
  task automatic test_defaults();
    check_register(REG_EXPIRE_TICKS, 32'd0);
    check_register(REG_GROUPS_IN_USE, 32'd1);
    send_select(16'h8000);
    issue_request(noisy_request(FUNC_TICK));
    issue_request(noisy_request(FUNC_UNUSED));
  endtask

  // Extreme weights and hops, all-zero weights, equal weights, rewrite, clears
  task automatic test_slot_table();
    set_register(REG_GROUPS_IN_USE, 32'd8);
    send_write(3'd0, 4'd0, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
    send_write(3'd0, 4'd15, 1'b1, 16'h0000, 32'h0000_0000);
    send_write(3'd0, 4'd7, 1'b1, 16'd100, 32'h0000_0707);
    // Group with only zero weights: threshold is 0, lower slot index wins
    send_write(3'd3, 4'd2, 1'b1, 16'd0, 32'h0000_0033);
    send_write(3'd3, 4'd9, 1'b1, 16'd0, 32'h0000_0039);
    // Equal weights: lower slot index goes first
    send_write(3'd7, 4'd4, 1'b1, 16'd5, 32'h0000_0074);
    send_write(3'd7, 4'd1, 1'b1, 16'd5, 32'h0000_0071);
    // Clear of an empty slot changes nothing
    send_write(3'd7, 4'd12, 1'b0, 16'hFFFF, 32'hDEAD_BEEF);
    send_select(16'h0000);
    send_select(16'hFFFF);
    send_select(16'h8000);
    // Rewrite a valid slot, then clear a valid one
    send_write(3'd0, 4'd7, 1'b1, 16'h4000, 32'hA5A5_A5A5);
    send_write(3'd7, 4'd1, 1'b0, 16'd0, 32'd0);
    send_select(16'hFFFF);
    send_select(16'h0001);
  endtask

  // Zero groups gives no results; counts above the table size saturate
  task automatic test_group_count();
    set_register(REG_GROUPS_IN_USE, 32'd0);
    send_select(16'h1234);
    set_register(REG_GROUPS_IN_USE, 32'd15);
    send_select(16'hC000);
    set_register(REG_GROUPS_IN_USE, 32'd1);
    send_select(16'h4000);
  endtask

  // Countdown, single expiry report, rearm by select and by register write
  task automatic test_expiry();
    set_register(REG_EXPIRE_TICKS, 32'd2);
    issue_request(noisy_request(FUNC_TICK));
    issue_request(noisy_request(FUNC_TICK));
    issue_request(noisy_request(FUNC_TICK));
    send_select(16'h2000);
    issue_request(noisy_request(FUNC_TICK));
    issue_request(noisy_request(FUNC_TICK));
    set_register(REG_EXPIRE_TICKS, 32'd1);
    issue_request(noisy_request(FUNC_TICK));
    set_register(REG_EXPIRE_TICKS, 32'hFFFF_FFFF);
    issue_request(noisy_request(FUNC_TICK));
    set_register(REG_EXPIRE_TICKS, 32'd0);
    issue_request(noisy_request(FUNC_TICK));
  endtask

  function automatic logic [15:0] pick_weight();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 16'h0000;
    if (roll < 20) return 16'hFFFF;
    // Small weights make ties frequent
    if (roll < 45) return 16'($urandom_range(0, 4));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_fraction();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 16'h0000;
    if (roll == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // Random traffic over several register settings
  task automatic test_random_traffic();
    logic [31:0] expire_set [PHASES];
    logic [31:0] group_set [PHASES];
    int unsigned sent;
    int unsigned roll;
    req_t r;
    expire_set = '{32'd0, 32'd1, 32'd3, 32'hFFFF_FFFF, 32'($urandom_range(2, 8)),
                   32'($urandom)};
    group_set = '{32'd8, 32'd1, 32'd15, 32'($urandom_range(2, 7)), 32'd8,
                  32'($urandom_range(0, 15))};
    for (int unsigned p = 0; p < PHASES; p++) begin
      set_register(REG_EXPIRE_TICKS, expire_set[p]);
      set_register(REG_GROUPS_IN_USE, group_set[p]);
      no_idle = (p % 3 == 2);
      sent = 0;
      while (sent < PHASE_REQUESTS) begin
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          r = noisy_request(FUNC_WRITE);
          r.slot_used = ($urandom_range(0, 4) != 0);
          r.entry_weight = pick_weight();
          send_write(r.group_index, r.slot_index, r.slot_used, r.entry_weight,
                     r.entry_hop);
          sent++;
        end else if (roll < 78) begin
          send_select(pick_fraction());
          sent++;
        end else if (roll < 96) begin
          issue_request(noisy_request(FUNC_TICK));
          sent++;
        end else begin
          // Ignored by the block: do not count it
          issue_request(noisy_request(FUNC_UNUSED));
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    for (int unsigned g = 0; g < N_GROUPS; g++) begin
      tbl_used[g] = '0;
      tbl_sum[g] = '0;
    end
    idle_left = '0;
    expiry_sent = 1'b0;
    cfg_expire = '0;
    cfg_groups = 4'd1;

    // Hold reset, then release it at a clock edge
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults();
    test_slot_table();
    test_group_count();
    test_expiry();
    test_random_traffic();

    // Drain, then watch a while longer for stray results
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
